[rtl/spe_pkg.sv]
package spe_pkg;

    // fixed field widths
    localparam int REQ_W    = 3;
    localparam int CNT_W    = 8;
    localparam int LEN_W    = 7;
    localparam int MASK_W   = 64;
    localparam int IDX_W    = 6;
    localparam int BUCKET_W = 8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_FILL   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ROT_L  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ROT_R  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DOUBLE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_HALVE  = 3'd4;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_COPY,
        ST_DONE
    } seq_state_t;

    // sequencer to datapath controls
    typedef struct packed {
        logic             fill_step;
        logic             copy_step;
        logic [IDX_W-1:0] idx;
        logic             out_load;
    } seq_ctrl_t;

endpackage

[rtl/spe_bucket.sv]
module spe_bucket (
    input  logic                      aclk,
    input  logic                      clear,
    input  logic                      step,
    input  logic [spe_pkg::LEN_W-1:0] pulses,
    input  logic [spe_pkg::LEN_W-1:0] steps,
    output logic                      hit
);
    import spe_pkg::*;

    logic [BUCKET_W-1:0] bucket_reg;
    logic [BUCKET_W-1:0] bucket_next;
    logic [BUCKET_W-1:0] sum;

    // one bucket step: add pulses, wrap at steps
    always_comb begin
        sum = bucket_reg + {1'b0, pulses};
        hit = (sum >= {1'b0, steps});
        if (hit) begin
            bucket_next = sum - {1'b0, steps};
        end else begin
            bucket_next = sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            bucket_reg <= '0;
        end else if (step) begin
            bucket_reg <= bucket_next;
        end
    end

endmodule

[rtl/spe_ctrl.sv]
module spe_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic                      start_fill,
    input  logic                      start_copy,
    input  logic [spe_pkg::LEN_W-1:0] limit,
    input  logic                      out_free,
    output logic                      idle,
    output spe_pkg::seq_ctrl_t        ctrl
);
    import spe_pkg::*;

    seq_state_t       state_reg;
    seq_state_t       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [LEN_W-1:0] limit_reg;
    logic [LEN_W-1:0] limit_next;
    logic             last;

    assign last = ({1'b0, idx_reg} == (limit_reg - LEN_W'(1)));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    if (start_fill) begin
                        state_next = ST_FILL;
                    end else if (start_copy) begin
                        state_next = ST_COPY;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FILL, ST_COPY: begin
                if (last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        idle           = (state_reg == ST_IDLE);
        ctrl.fill_step = (state_reg == ST_FILL);
        ctrl.copy_step = (state_reg == ST_COPY);
        ctrl.idx       = idx_reg;
        ctrl.out_load  = (state_reg == ST_DONE) && out_free;
    end

    // iteration counter and limit
    always_comb begin
        idx_next   = idx_reg;
        limit_next = limit_reg;
        if (start) begin
            idx_next   = '0;
            limit_next = limit;
        end else if (ctrl.fill_step || ctrl.copy_step) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            limit_reg <= LEN_W'(1);
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            limit_reg <= limit_next;
        end
    end

endmodule

[rtl/step_pattern_engine.sv]
// Step pattern engine: holds a row of 64 step enable bits and a pattern length
// (reset: all bits clear, length 16 or MAX_STEPS if smaller). Each request on
// the s_ channel runs one operation (euclidean fill, rotate left, rotate right,
// double, halve; other codes change nothing) and returns exactly one result on
// the m_ channel with the new length and all 64 bits. One request is worked on
// at a time. A fill runs one bucket step per pattern step through a single
// shared add/compare unit, over the clamped step count (at most MAX_STEPS).
// A double copies one bit per cycle, new length - old length bits in all;
// rotate, halve and unused codes go straight to the result. The next request
// is taken once the result has moved into the output register, even if it
// is not yet read.
module step_pattern_engine #(
    parameter int MAX_STEPS = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [spe_pkg::REQ_W-1:0]  s_req_type,
    input  logic [spe_pkg::CNT_W-1:0]  s_step_count,
    input  logic [spe_pkg::CNT_W-1:0]  s_pulse_count,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [spe_pkg::LEN_W-1:0]  m_length,
    output logic [spe_pkg::MASK_W-1:0] m_enable_mask
);
    import spe_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_STEPS);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_STEPS);
    localparam logic [LEN_W-1:0] RESET_LEN = (MAX_STEPS < 16) ? LEN_W'(MAX_STEPS) : LEN_W'(16);

    logic [MASK_W-1:0] bits_reg;
    logic [MASK_W-1:0] bits_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [LEN_W-1:0]  base_reg;
    logic [LEN_W-1:0]  base_next;
    logic [LEN_W-1:0]  steps_reg;
    logic [LEN_W-1:0]  pulses_reg;
    logic              m_valid_reg;
    logic [LEN_W-1:0]  m_length_reg;
    logic [MASK_W-1:0] m_mask_reg;

    logic              accept;
    logic              idle;
    logic              out_free;
    seq_ctrl_t         ctrl;
    logic              bucket_hit;

    logic [LEN_W-1:0]  steps_clamp;
    logic [LEN_W-1:0]  pulses_clamp;
    logic [CNT_W-1:0]  dbl_raw;
    logic [LEN_W-1:0]  dbl_len;
    logic [LEN_W-1:0]  half_len;
    logic              start_fill;
    logic              start_copy;
    logic [LEN_W-1:0]  limit;
    logic [MASK_W-1:0] seg_mask;
    logic [MASK_W-1:0] seg;
    logic [IDX_W-1:0]  top_idx;
    logic [MASK_W-1:0] top_bit;
    logic [MASK_W-1:0] rot_left;
    logic [MASK_W-1:0] rot_right;
    logic [LEN_W-1:0]  copy_dst;

    assign accept   = s_valid && s_ready;
    assign s_ready  = idle;
    assign out_free = !m_valid_reg || m_ready;

    // operand clamping for the fill
    always_comb begin
        if (s_step_count == '0) begin
            steps_clamp = LEN_W'(1);
        end else if (s_step_count > MAX_CNT) begin
            steps_clamp = MAX_LEN;
        end else begin
            steps_clamp = s_step_count[LEN_W-1:0];
        end
        if (s_pulse_count > {1'b0, steps_clamp}) begin
            pulses_clamp = steps_clamp;
        end else begin
            pulses_clamp = s_pulse_count[LEN_W-1:0];
        end
    end

    // new lengths for double and halve
    always_comb begin
        dbl_raw = {len_reg, 1'b0};
        if (dbl_raw > MAX_CNT) begin
            dbl_len = MAX_LEN;
        end else begin
            dbl_len = dbl_raw[LEN_W-1:0];
        end
        half_len = len_reg >> 1;
        if (half_len == '0) begin
            half_len = LEN_W'(1);
        end
    end

    // rotation within the current length
    always_comb begin
        seg_mask  = ~({MASK_W{1'b1}} << len_reg);
        seg       = bits_reg & seg_mask;
        top_idx   = IDX_W'(len_reg - LEN_W'(1));
        top_bit   = {{(MASK_W-1){1'b0}}, seg[0]} << top_idx;
        rot_left  = (seg >> 1) | top_bit;
        rot_right = ((seg << 1) & seg_mask) | {{(MASK_W-1){1'b0}}, seg[top_idx]};
    end

    // sequencer start
    always_comb begin
        start_fill = accept && (s_req_type == REQ_FILL);
        start_copy = accept && (s_req_type == REQ_DOUBLE) && (dbl_len > len_reg);
        if (s_req_type == REQ_FILL) begin
            limit = steps_clamp;
        end else begin
            limit = dbl_len - len_reg;
        end
    end

    spe_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept),
        .start_fill (start_fill),
        .start_copy (start_copy),
        .limit      (limit),
        .out_free   (out_free),
        .idle       (idle),
        .ctrl       (ctrl)
    );

    spe_bucket u_bucket (
        .aclk   (aclk),
        .clear  (accept),
        .step   (ctrl.fill_step),
        .pulses (pulses_reg),
        .steps  (steps_reg),
        .hit    (bucket_hit)
    );

    assign copy_dst = base_reg + {1'b0, ctrl.idx};

    // pattern state update
    always_comb begin
        bits_next = bits_reg;
        len_next  = len_reg;
        base_next = base_reg;
        if (accept) begin
            case (s_req_type)
                REQ_FILL: begin
                    len_next = steps_clamp;
                end
                REQ_ROT_L: begin
                    if (len_reg > LEN_W'(1)) begin
                        bits_next = (bits_reg & ~seg_mask) | rot_left;
                    end
                end
                REQ_ROT_R: begin
                    if (len_reg > LEN_W'(1)) begin
                        bits_next = (bits_reg & ~seg_mask) | rot_right;
                    end
                end
                REQ_DOUBLE: begin
                    len_next  = dbl_len;
                    base_next = len_reg;
                end
                REQ_HALVE: begin
                    len_next = half_len;
                end
                default: begin
                    len_next = len_reg;
                end
            endcase
        end
        if (ctrl.fill_step) begin
            bits_next[ctrl.idx] = bucket_hit;
        end
        if (ctrl.copy_step) begin
            bits_next[copy_dst[IDX_W-1:0]] = bits_reg[ctrl.idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg <= '0;
            len_reg  <= RESET_LEN;
        end else begin
            bits_reg <= bits_next;
            len_reg  <= len_next;
        end
    end

    // fill operands and copy base
    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        if (accept) begin
            steps_reg  <= steps_clamp;
            pulses_reg <= pulses_clamp;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_length_reg <= len_reg;
            m_mask_reg   <= bits_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_length      = m_length_reg;
    assign m_enable_mask = m_mask_reg;

endmodule

[rtl/spe_checker.sv]
module spe_checker #(
    parameter int MAX_STEPS = 64
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [spe_pkg::LEN_W-1:0]  m_length,
    input logic [spe_pkg::MASK_W-1:0] m_enable_mask
);
    import spe_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_STEPS);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_length) && $stable(m_enable_mask))
        else $error("result changed while stalled");

    // one request in flight: ready drops right after a transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held after request transaction");

    // reported length stays in range
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_length != '0) && (m_length <= MAX_LEN))
        else $error("length out of range");

    // no enable bit beyond the largest pattern
    a_mask_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_enable_mask >> MAX_STEPS) == '0))
        else $error("enable bit beyond max steps");

    // an idle block with no request never raises a result
    a_no_result_without_request: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && s_ready && !s_valid |=> !m_valid)
        else $error("result without request");

endmodule

bind step_pattern_engine spe_checker #(.MAX_STEPS(MAX_STEPS)) u_spe_checker (.*);
